FILE: rtl/keyframe_pose_interpolator_defines.svh
// Assertion macros shared by the checker files of the keyframe pose interpolator.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef KEYFRAME_POSE_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_POSE_INTERPOLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyframe_pose_interpolator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyframe_pose_interpolator: next-cycle check failed");

`endif

FILE: rtl/kpi_pkg.sv
// Package of the keyframe pose interpolator: operation codes, register indexes
// and the fixed field widths. It depends on nothing else.
package kpi_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESTART = 2'd2,
    OP_TOGGLE  = 2'd3
  } op_t;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_KEY_FRAMES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_KEY_FRAMES = 2'd1;

  localparam int KEY_W       = 2;
  localparam int PART_IDX_W  = 4;
  localparam int CHAN_W      = 3;
  localparam int CHANNELS    = 6;
  localparam int RATE_W      = 16;
  localparam int FRAMES_RESET = 300;

endpackage

FILE: rtl/kpi_rate_div.sv
// Restoring divider that forms the Q0.16 blend rate frame / duration.
// Uses kpi_pkg for the rate width; one quotient bit per cycle.
module kpi_rate_div
  import kpi_pkg::*;
#(
  parameter int FRAME_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [FRAME_WIDTH-1:0] frame,
  input  logic [FRAME_WIDTH-1:0] dur,
  output logic                   done,
  output logic [RATE_W-1:0]      rate
);

  localparam int STEP_W = $clog2(RATE_W);

  logic                   busy_r;
  logic                   done_r;
  logic [STEP_W-1:0]      step_r;
  logic [FRAME_WIDTH-1:0] rem_r;
  logic [FRAME_WIDTH-1:0] dur_r;
  logic [RATE_W-1:0]      quo_r;
  logic [FRAME_WIDTH:0]   rem2;
  logic                   fits;

  // The remainder always stays below the divisor, so doubling it needs one more bit.
  assign rem2 = {rem_r, 1'b0};
  assign fits = (rem2 >= {1'b0, dur_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dur_r  <= dur;
        step_r <= '0;
        if (frame >= dur) begin
          // A frame at or past the duration saturates the rate.
          quo_r  <= '1;
          done_r <= 1'b1;
        end else begin
          rem_r  <= frame;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        quo_r <= {quo_r[RATE_W-2:0], fits};
        if (fits) begin
          rem_r <= FRAME_WIDTH'(rem2 - {1'b0, dur_r});
        end else begin
          rem_r <= rem2[FRAME_WIDTH-1:0];
        end
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(RATE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rate = quo_r;

endmodule

FILE: rtl/keyframe_pose_interpolator.sv
// Keyframe pose interpolator: pose table, play control and the blend sequencer.
// Depends on kpi_pkg and instantiates kpi_rate_div.
//
// Usage. Words enter on the in_ channel (valid/ready) and carry an operation:
// tick, load one table entry, restart at key 0, or toggle play. Only a tick
// produces output: NUM_PARTS words on the out_ channel (valid/ready), one per
// part in increasing order, with out_last_part set on the final one. The two
// key durations are written on the cfg_ channel, which is always ready.
// Load, restart and toggle words are handled in the idle state. A tick passes
// from its accept through the rate divider (which is cut short when the
// frame count has reached the duration), then, per channel, through the single
// read-subtract-multiply-add path, then one emit step per part and a final
// frame update; in_ready is low for the whole tick. A stalled receiver holds
// the sequencer at the next part; the final word may still wait in the output
// register while a new word is accepted. Reset clears the key, the frame
// count, play (paused) and the output valid and sets both durations to 300;
// the pose table is not cleared and must be loaded first.
module keyframe_pose_interpolator
  import kpi_pkg::*;
#(
  parameter int NUM_PARTS   = 10,
  parameter int NUM_KEYS    = 3,
  parameter int VALUE_WIDTH = 16,
  parameter int FRAME_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [KEY_W-1:0]              in_key_select,
  input  logic [PART_IDX_W-1:0]         in_part_select,
  input  logic [CHAN_W-1:0]             in_channel_select,
  input  logic signed [VALUE_WIDTH-1:0] in_entry_value,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [PART_IDX_W-1:0]         out_part_index,
  output logic signed [VALUE_WIDTH-1:0] out_pos_x,
  output logic signed [VALUE_WIDTH-1:0] out_pos_y,
  output logic signed [VALUE_WIDTH-1:0] out_pos_z,
  output logic signed [VALUE_WIDTH-1:0] out_rot_x,
  output logic signed [VALUE_WIDTH-1:0] out_rot_y,
  output logic signed [VALUE_WIDTH-1:0] out_rot_z,
  output logic                          out_last_part,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [FRAME_WIDTH-1:0]        cfg_data
);

  localparam int KEY_SPAN    = NUM_PARTS * CHANNELS;
  localparam int TABLE_DEPTH = NUM_KEYS * KEY_SPAN;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int PART_W      = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int PROD_W      = VALUE_WIDTH + RATE_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_DIFF,
    ST_MUL,
    ST_ADD,
    ST_EMIT,
    ST_UPDATE
  } state_t;

  state_t                   state_r;
  logic [KEY_W-1:0]         key_r;
  logic [FRAME_WIDTH-1:0]   frame_r;
  logic                     playing_r;
  logic [FRAME_WIDTH-1:0]   first_frames_r;
  logic [FRAME_WIDTH-1:0]   second_frames_r;
  logic [ADDR_W-1:0]        addr_a_r;
  logic [CHAN_W-1:0]        ch_r;
  logic [PART_W-1:0]        part_r;
  logic [VALUE_WIDTH-1:0]   a_r;
  logic signed [VALUE_WIDTH:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [VALUE_WIDTH-1:0]   chan_buf_r [CHANNELS];
  logic [VALUE_WIDTH-1:0]   out_val_r [CHANNELS];
  logic [PART_IDX_W-1:0]    out_part_r;
  logic                     out_last_r;
  logic                     out_valid_r;

  // Pose table, two registered read ports (current key and next key).
  logic [VALUE_WIDTH-1:0]   pose_table [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0]   rd_a_r;
  logic [VALUE_WIDTH-1:0]   rd_b_r;
  logic [ADDR_W-1:0]        addr_b;
  logic [ADDR_W-1:0]        waddr;
  logic                     load_ok;
  logic                     wr_en;

  logic                     in_accept;
  op_t                      op;
  logic [FRAME_WIDTH-1:0]   dur_sel;
  logic [FRAME_WIDTH-1:0]   dur_eff;
  logic                     div_start;
  logic                     div_done;
  logic [RATE_W-1:0]        rate;
  logic [VALUE_WIDTH-1:0]   blend;
  logic                     out_free;
  logic                     part_last;
  logic [FRAME_WIDTH-1:0]   frame_adv;
  logic [KEY_W-1:0]         key_adv;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign op        = op_t'(in_operation);

  // A duration register of zero counts as one frame.
  assign dur_sel   = (key_r == '0) ? first_frames_r : second_frames_r;
  assign dur_eff   = (dur_sel == '0) ? FRAME_WIDTH'(1) : dur_sel;
  assign div_start = in_accept && (op == OP_TICK);

  kpi_rate_div #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_rate_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .frame (frame_r),
    .dur   (dur_eff),
    .done  (div_done),
    .rate  (rate)
  );

  // The next key is always the current one plus one, a key span further on.
  assign addr_b = addr_a_r + ADDR_W'(KEY_SPAN);

  assign load_ok = (int'(in_key_select) < NUM_KEYS) && (int'(in_part_select) < NUM_PARTS)
                   && (int'(in_channel_select) < CHANNELS);
  assign waddr   = ADDR_W'((int'(in_key_select) * NUM_PARTS + int'(in_part_select))
                           * CHANNELS + int'(in_channel_select));
  assign wr_en   = in_accept && (op == OP_LOAD) && load_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pose_table[waddr] <= in_entry_value;
    end
    rd_a_r <= pose_table[addr_a_r];
    rd_b_r <= pose_table[addr_b];
  end

  // The low bits of a + floor(prod / 2^16) are the low bits of a plus the
  // product's upper slice, since the arithmetic shift is a floor.
  assign blend     = a_r + prod_r[RATE_W +: VALUE_WIDTH];
  assign out_free  = !out_valid_r || out_ready;
  assign part_last = (part_r == PART_W'(NUM_PARTS - 1));
  assign frame_adv = frame_r + FRAME_WIDTH'(playing_r);
  assign key_adv   = key_r + KEY_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      key_r           <= '0;
      frame_r         <= '0;
      playing_r       <= 1'b0;
      first_frames_r  <= FRAME_WIDTH'(FRAMES_RESET);
      second_frames_r <= FRAME_WIDTH'(FRAMES_RESET);
      out_valid_r     <= 1'b0;
      ch_r            <= '0;
      part_r          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIRST_KEY_FRAMES) begin
          first_frames_r <= cfg_data;
        end else if (cfg_index == CFG_SECOND_KEY_FRAMES) begin
          second_frames_r <= cfg_data;
        end
      end

      // A taken word empties the output register unless the next part
      // is loaded into it in the same cycle.
      if (out_ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            case (op)
              OP_TICK: begin
                addr_a_r <= (key_r != '0) ? ADDR_W'(KEY_SPAN) : '0;
                ch_r     <= '0;
                part_r   <= '0;
                state_r  <= ST_DIV;
              end
              OP_RESTART: begin
                key_r   <= '0;
                frame_r <= '0;
              end
              OP_TOGGLE: begin
                playing_r <= !playing_r;
              end
              default: begin
                // Loads go straight to the table write port.
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          a_r     <= rd_a_r;
          diff_r  <= $signed({rd_b_r[VALUE_WIDTH-1], rd_b_r})
                     - $signed({rd_a_r[VALUE_WIDTH-1], rd_a_r});
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= PROD_W'(diff_r) * PROD_W'($signed({1'b0, rate}));
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          chan_buf_r[ch_r] <= blend;
          addr_a_r         <= addr_a_r + ADDR_W'(1);
          if (ch_r == CHAN_W'(CHANNELS - 1)) begin
            ch_r    <= '0;
            state_r <= ST_EMIT;
          end else begin
            ch_r    <= ch_r + CHAN_W'(1);
            state_r <= ST_READ;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_val_r   <= chan_buf_r;
            out_part_r  <= PART_IDX_W'(part_r);
            out_last_r  <= part_last;
            out_valid_r <= 1'b1;
            if (part_last) begin
              state_r <= ST_UPDATE;
            end else begin
              part_r  <= part_r + PART_W'(1);
              state_r <= ST_READ;
            end
          end
        end
        ST_UPDATE: begin
          // Advance the frame while playing, step the key at its duration, and wrap
          // from the last key that has a next key (NUM_KEYS - 2) back to key 0.
          if (frame_adv >= dur_eff) begin
            frame_r <= '0;
            if (key_adv >= KEY_W'(NUM_KEYS - 1)) begin
              key_r <= '0;
            end else begin
              key_r <= key_adv;
            end
          end else begin
            frame_r <= frame_adv;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_part_index = out_part_r;
  assign out_pos_x      = out_val_r[0];
  assign out_pos_y      = out_val_r[1];
  assign out_pos_z      = out_val_r[2];
  assign out_rot_x      = out_val_r[3];
  assign out_rot_y      = out_val_r[4];
  assign out_rot_z      = out_val_r[5];
  assign out_last_part  = out_last_r;

endmodule

FILE: rtl/kpi_checker.sv
// Port-level checks for the keyframe pose interpolator, bound to the top level.
// Depends on kpi_pkg and keyframe_pose_interpolator_defines.svh.
`include "keyframe_pose_interpolator_defines.svh"

module kpi_checker
  import kpi_pkg::*;
#(
  parameter int NUM_PARTS = 10
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            in_operation,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PART_IDX_W-1:0] out_part_index,
  input logic                  out_last_part
);

  // A stalled result word keeps its part number.
  `KPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_part_index))

  // While a tick's run still has parts to come, no new word is taken.
  `KPI_ASSERT_SAME(a_busy_in_run, out_valid && !out_last_part, !in_ready)

  // The final word of a run carries the highest part number.
  `KPI_ASSERT_SAME(a_last_index, out_valid && out_last_part,
                   out_part_index == PART_IDX_W'(NUM_PARTS - 1))

  // A word other than a tick never starts a result.
  `KPI_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && !out_valid
                   && (in_operation != OP_TICK), !out_valid)

endmodule

bind keyframe_pose_interpolator kpi_checker #(
  .NUM_PARTS (NUM_PARTS)
) u_kpi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_operation   (in_operation),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_part_index (out_part_index),
  .out_last_part  (out_last_part)
);
